### design/dvu_pkg.sv
`timescale 1ns / 1ps

package dvu_pkg;

  localparam int ActionW = 2;
  localparam int IndexW  = 4;
  localparam int CostW   = 17;

  typedef logic [ActionW-1:0]      action_t;
  typedef logic [IndexW-1:0]       index_t;
  typedef logic signed [CostW-1:0] cost_t;

  localparam action_t ActLoad   = 2'd0;
  localparam action_t ActAdvert = 2'd1;
  localparam action_t ActRead   = 2'd2;

  localparam cost_t CostUnknown = 17'h1FFFF;
  localparam cost_t CostMax     = 17'h0FFFF;

endpackage

### design/dvu_cfg_if.sv
`timescale 1ns / 1ps

interface dvu_cfg_if;
  logic              valid;
  logic              ready;
  dvu_pkg::index_t   self_index;

  modport source (output valid, output self_index, input ready);
  modport sink   (input valid, input self_index, output ready);
endinterface

### design/dvu_in_if.sv
`timescale 1ns / 1ps

interface dvu_in_if;
  logic              valid;
  logic              ready;
  dvu_pkg::action_t  action;
  dvu_pkg::index_t   entry_index;
  dvu_pkg::index_t   source_node;
  dvu_pkg::cost_t    cost_value;
  logic              last_entry;

  modport source (output valid, output action, output entry_index, output source_node,
                  output cost_value, output last_entry, input ready);
  modport sink   (input valid, input action, input entry_index, input source_node,
                  input cost_value, input last_entry, output ready);
endinterface

### design/dvu_out_if.sv
`timescale 1ns / 1ps

interface dvu_out_if;
  logic              valid;
  logic              ready;
  dvu_pkg::index_t   result_index;
  dvu_pkg::cost_t    result_cost;
  logic              entry_updated;
  logic              advertise_now;

  modport source (output valid, output result_index, output result_cost,
                  output entry_updated, output advertise_now, input ready);
  modport sink   (input valid, input result_index, input result_cost,
                  input entry_updated, input advertise_now, output ready);
endinterface

### design/distance_vector_update_core.sv
`timescale 1ns / 1ps
// path: a beat accepted into the input register moves on to the result register once the
//   result side is free, and the result beat is taken from there
// throughput: one beat per cycle while the result side is not stalled; the tables are read and
//   written back in the compute stage, so a following beat always sees the updated entries
// reset: distance and link tables read as unknown (-1), self index 0, no beats in flight
module distance_vector_update_core #(
  parameter int NODES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dvu_cfg_if.sink       cfg_i,
  dvu_in_if.sink        in_i,
  dvu_out_if.source     out_o
);

  // only 16 destinations can be named by the index field
  localparam int Depth = (NODES < 16) ? NODES : 16;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  dvu_pkg::cost_t   dist_q [Depth];
  dvu_pkg::cost_t   link_q [Depth];
  logic             vec_chg_q, vec_chg_d;
  dvu_pkg::index_t  self_q;

  // input register
  logic             in_vld_q;
  dvu_pkg::action_t act_q;
  dvu_pkg::index_t  dst_q;
  dvu_pkg::index_t  src_q;
  dvu_pkg::cost_t   cost_q;
  logic             last_q;

  // result register
  logic             out_vld_q, out_vld_d;
  dvu_pkg::index_t  res_idx_q;
  dvu_pkg::cost_t   res_cost_q, res_cost_d;
  logic             res_upd_q;
  logic             res_adv_q, res_adv_d;

  logic             go;
  logic             in_take;
  logic             is_load, is_adv;
  logic             dst_ok, src_ok;
  dvu_pkg::cost_t   cost_n, link, cur, sum_sat;
  logic [16:0]      sum_w;
  logic             upd;
  logic             chg_any;

  assign go      = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || go;
  assign in_take = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign is_load = (act_q == dvu_pkg::ActLoad);
  assign is_adv  = (act_q == dvu_pkg::ActAdvert);

  assign dst_ok = 32'(dst_q) < NODES;
  assign src_ok = 32'(src_q) < NODES;

  // any negative cost counts as unknown
  assign cost_n = cost_q[16] ? dvu_pkg::CostUnknown : cost_q;
  assign link   = src_ok ? link_q[src_q[IdxW-1:0]] : dvu_pkg::CostUnknown;
  assign cur    = dst_ok ? dist_q[dst_q[IdxW-1:0]] : dvu_pkg::CostUnknown;

  assign sum_w   = {1'b0, link[15:0]} + {1'b0, cost_n[15:0]};
  assign sum_sat = sum_w[16] ? dvu_pkg::CostMax : dvu_pkg::cost_t'(sum_w);

  assign upd = is_adv && dst_ok && !link[16] && !cost_n[16] && (cost_n != '0) &&
               (dst_q != self_q) && (cur[16] || (cur[15:0] > sum_sat[15:0]));

  assign chg_any = vec_chg_q || upd;

  always_comb begin
    vec_chg_d = vec_chg_q;
    res_adv_d = 1'b0;
    if (is_adv) begin
      vec_chg_d = last_q ? 1'b0 : chg_any;
      res_adv_d = last_q && chg_any;
    end
    if (is_load && dst_ok) begin
      res_cost_d = cost_n;
    end else if (upd) begin
      res_cost_d = sum_sat;
    end else begin
      res_cost_d = cur;
    end
    if (go) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vec_chg_q <= 1'b0;
      self_q    <= '0;
      for (int i = 0; i < Depth; i++) begin
        dist_q[i] <= dvu_pkg::CostUnknown;
        link_q[i] <= dvu_pkg::CostUnknown;
      end
    end else begin
      if (cfg_i.valid) begin
        self_q <= cfg_i.self_index;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (go) begin
        in_vld_q <= 1'b0;
      end
      out_vld_q <= out_vld_d;
      if (go) begin
        vec_chg_q <= vec_chg_d;
        if (is_load && dst_ok) begin
          link_q[dst_q[IdxW-1:0]] <= cost_n;
          dist_q[dst_q[IdxW-1:0]] <= cost_n;
        end else if (upd) begin
          dist_q[dst_q[IdxW-1:0]] <= sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q  <= in_i.action;
      dst_q  <= in_i.entry_index;
      src_q  <= in_i.source_node;
      cost_q <= in_i.cost_value;
      last_q <= in_i.last_entry;
    end
    if (go) begin
      res_idx_q  <= dst_q;
      res_cost_q <= res_cost_d;
      res_upd_q  <= upd;
      res_adv_q  <= res_adv_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.result_index  = res_idx_q;
  assign out_o.result_cost   = res_cost_q;
  assign out_o.entry_updated = res_upd_q;
  assign out_o.advertise_now = res_adv_q;

  // a new beat never lands on a full input register behind a stalled result
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> !(in_vld_q && out_vld_q && !out_o.ready))
    else $error("input register overrun");

  // an update always leaves a known distance
  a_upd_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_upd_q |-> !res_cost_q[16])
    else $error("updated entry reads as unknown");

  // the router's own entry is never lowered by an advert
  a_self_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && upd |-> dst_q != self_q)
    else $error("own entry changed by advert");

  // end of vector always clears the change flag
  a_vec_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && is_adv && last_q |=> !vec_chg_q)
    else $error("change flag kept after last entry");

endmodule

### bench/tb_distance_vector_update_core.sv
`timescale 1ns / 1ps

module tb_distance_vector_update_core;

  localparam int               NumNodes   = 16;
  localparam int               CycleLimit = 400000;
  localparam dvu_pkg::action_t ActSpare   = 2'd3;

  typedef struct packed {
    dvu_pkg::action_t action;
    dvu_pkg::index_t  entry_index;
    dvu_pkg::index_t  source_node;
    dvu_pkg::cost_t   cost_value;
    logic             last_entry;
  } hop_item_t;

  typedef struct packed {
    dvu_pkg::index_t idx;
    dvu_pkg::cost_t  cost;
    logic            updated;
    logic            advertise;
  } route_report_t;

  // shadow routing tables and the queue of routes still owed by the block
  class route_scoreboard;
    dvu_pkg::cost_t  dist_tab[NumNodes];
    dvu_pkg::cost_t  link_tab[NumNodes];
    bit              vec_changed;
    dvu_pkg::index_t self_idx;
    route_report_t   owed[$];
    int              errors;

    function new();
      foreach (dist_tab[i]) begin
        dist_tab[i] = dvu_pkg::CostUnknown;
        link_tab[i] = dvu_pkg::CostUnknown;
      end
      vec_changed = 1'b0;
      self_idx    = '0;
      errors      = 0;
    endfunction

    function void note_input(hop_item_t it);
      route_report_t  exp;
      dvu_pkg::cost_t c;
      int             link;
      int             sum;
      int             cur;
      // any negative cost counts as unknown
      c   = (it.cost_value < 0) ? dvu_pkg::CostUnknown : it.cost_value;
      exp = '0;
      exp.idx = it.entry_index;
      case (it.action)
        dvu_pkg::ActLoad: begin
          link_tab[it.entry_index] = c;
          dist_tab[it.entry_index] = c;
        end
        dvu_pkg::ActAdvert: begin
          link = link_tab[it.source_node];
          if (link >= 0 && c > 0 && it.entry_index != self_idx) begin
            sum = link + int'(c);
            if (sum > int'(dvu_pkg::CostMax)) sum = int'(dvu_pkg::CostMax);
            cur = dist_tab[it.entry_index];
            if (cur < 0 || cur > sum) begin
              dist_tab[it.entry_index] = dvu_pkg::cost_t'(sum);
              exp.updated = 1'b1;
              vec_changed = 1'b1;
            end
          end
          if (it.last_entry) begin
            exp.advertise = vec_changed;
            vec_changed   = 1'b0;
          end
        end
        default: ;
      endcase
      exp.cost = dist_tab[it.entry_index];
      owed.push_back(exp);
    endfunction

    function void check_result(route_report_t got);
      route_report_t exp;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected route beat: idx %0d cost %0d upd %b adv %b",
                   got.idx, got.cost, got.updated, got.advertise);
        return;
      end
      exp = owed.pop_front();
      if (got.idx !== exp.idx || got.cost !== exp.cost ||
          got.updated !== exp.updated || got.advertise !== exp.advertise) begin
        errors++;
        if (errors <= 10)
          $display({"route mismatch: exp idx %0d cost %0d upd %b adv %b, ",
                    "got idx %0d cost %0d upd %b adv %b"},
                   exp.idx, exp.cost, exp.updated, exp.advertise,
                   got.idx, got.cost, got.updated, got.advertise);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  dvu_cfg_if cfg_bus ();
  dvu_in_if  in_bus ();
  dvu_out_if out_bus ();

  distance_vector_update_core #(
    .NODES(NumNodes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  route_scoreboard sb;
  bit              quiet;
  int              stall_hold;
  int              cycle_count;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // check results before noting the beat accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_result({out_bus.result_index, out_bus.result_cost,
                         out_bus.entry_updated, out_bus.advertise_now});
      if (in_bus.valid && in_bus.ready)
        sb.note_input({in_bus.action, in_bus.entry_index, in_bus.source_node,
                       in_bus.cost_value, in_bus.last_entry});
      if (cfg_bus.valid && cfg_bus.ready)
        sb.self_idx = cfg_bus.self_index;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk_i) begin
    if (stall_hold > 0) begin
      out_bus.ready = 1'b0;
      stall_hold--;
    end else if (quiet) begin
      out_bus.ready = 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_bus.ready = 1'b0;
      stall_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 29);
    end else begin
      out_bus.ready = 1'b1;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dvu_pkg::cost_t rand_cost();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return dvu_pkg::cost_t'($urandom_range(1, 300));
    if (r < 70) return '0;
    if (r < 78) return dvu_pkg::CostUnknown;
    if (r < 85) return dvu_pkg::cost_t'($urandom_range(65536, 131071));
    if (r < 95) return dvu_pkg::cost_t'($urandom_range(60000, 65535));
    return dvu_pkg::cost_t'($urandom_range(0, 131071));
  endfunction

  function automatic hop_item_t pack_hop(dvu_pkg::action_t a, dvu_pkg::index_t d,
                                         dvu_pkg::index_t s, dvu_pkg::cost_t c, logic l);
    hop_item_t it;
    it.action      = a;
    it.entry_index = d;
    it.source_node = s;
    it.cost_value  = c;
    it.last_entry  = l;
    return it;
  endfunction

  task automatic send_item(hop_item_t it, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid       = 1'b1;
    in_bus.action      = it.action;
    in_bus.entry_index = it.entry_index;
    in_bus.source_node = it.source_node;
    in_bus.cost_value  = it.cost_value;
    in_bus.last_entry  = it.last_entry;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic quiesce();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_self(dvu_pkg::index_t v);
    @(negedge clk_i);
    cfg_bus.valid      = 1'b1;
    cfg_bus.self_index = v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic directed_routes();
    send_item(pack_hop(dvu_pkg::ActRead,   4'd5,  4'd0,  17'sd0,     1'b0), 0);
    send_item(pack_hop(ActSpare,           4'd15, 4'd15, 17'sd0,     1'b1), 0);
    // advert over a link that was never loaded
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd7,  4'd3,  17'sd10,    1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActLoad,   4'd3,  4'd0,  17'sd4,     1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActLoad,   4'd0,  4'd9,  17'sd0,     1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd7,  4'd3,  17'sd10,    1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd7,  4'd3,  17'sd0,     1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd7,  4'd3,  17'h1FFFB,  1'b0), 0);
    // own entry stays put, vector still reports the earlier change
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd0,  4'd3,  17'sd1,     1'b1), 0);
    send_item(pack_hop(dvu_pkg::ActLoad,   4'd15, 4'd0,  dvu_pkg::CostMax, 1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd9,  4'd15, dvu_pkg::CostMax, 1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd9,  4'd15, 17'sd1,     1'b1), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd9,  4'd3,  17'sd2,     1'b1), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd9,  4'd3,  17'sd100,   1'b1), 0);
    send_item(pack_hop(dvu_pkg::ActLoad,   4'd4,  4'd0,  17'h10000,  1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd2,  4'd4,  17'sd3,     1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActLoad,   4'd3,  4'd0,  dvu_pkg::CostUnknown, 1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd11, 4'd3,  17'sd5,     1'b1), 0);
    // zero-cost link is a valid link
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd12, 4'd0,  17'sd1,     1'b0), 0);
    send_item(pack_hop(dvu_pkg::ActAdvert, 4'd12, 4'd0,  17'h1FFFF,  1'b1), 0);
    send_item(pack_hop(dvu_pkg::ActRead,   4'd12, 4'd0,  17'sd0,     1'b0), 0);
    send_item(pack_hop(ActSpare,           4'd9,  4'd0,  17'h1FFFF,  1'b0), 0);
  endtask

  task automatic random_routes(int n_items);
    int              sent;
    int              kind;
    int              len;
    bit              broken;
    dvu_pkg::index_t src;
    dvu_pkg::index_t known[$];
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_item(pack_hop(dvu_pkg::ActLoad, dvu_pkg::index_t'($urandom_range(0, 15)),
                           dvu_pkg::index_t'($urandom_range(0, 15)), rand_cost(),
                           1'($urandom)),
                  gap_len());
        sent++;
      end else if (kind < 80) begin
        // a whole vector from a neighbour, mostly one with a live link
        known.delete();
        foreach (sb.link_tab[i])
          if (sb.link_tab[i] >= 0) known.push_back(dvu_pkg::index_t'(i));
        if (known.size() > 0 && $urandom_range(0, 9) != 0)
          src = known[$urandom_range(0, known.size() - 1)];
        else
          src = dvu_pkg::index_t'($urandom_range(0, 15));
        len    = $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++)
          send_item(pack_hop(dvu_pkg::ActAdvert, dvu_pkg::index_t'($urandom_range(0, 15)),
                             src, rand_cost(), (k == len - 1) && !broken), gap_len());
        sent += len;
      end else if (kind < 95) begin
        send_item(pack_hop($urandom_range(0, 1) ? dvu_pkg::ActRead : ActSpare,
                           dvu_pkg::index_t'($urandom_range(0, 15)),
                           dvu_pkg::index_t'($urandom_range(0, 15)),
                           dvu_pkg::cost_t'($urandom_range(0, 131071)), 1'($urandom)),
                  gap_len());
        sent++;
      end else begin
        send_item(pack_hop(dvu_pkg::action_t'($urandom_range(0, 3)),
                           dvu_pkg::index_t'($urandom_range(0, 15)),
                           dvu_pkg::index_t'($urandom_range(0, 15)),
                           dvu_pkg::cost_t'($urandom_range(0, 131071)), 1'($urandom)),
                  gap_len());
        sent++;
      end
    end
  endtask

  initial begin
    dvu_pkg::index_t self_plan[4];
    sb                 = new();
    quiet              = 1'b1;
    stall_hold         = 0;
    cycle_count        = 0;
    rst_ni             = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.self_index = '0;
    in_bus.valid       = 1'b0;
    in_bus.action      = dvu_pkg::ActLoad;
    in_bus.entry_index = '0;
    in_bus.source_node = '0;
    in_bus.cost_value  = '0;
    in_bus.last_entry  = 1'b0;
    out_bus.ready      = 1'b0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    write_self(4'd0);
    directed_routes();
    quiesce();

    self_plan[0] = 4'd15;
    self_plan[1] = 4'd0;
    self_plan[2] = dvu_pkg::index_t'($urandom_range(1, 14));
    self_plan[3] = 4'd7;
    for (int p = 0; p < 4; p++) begin
      write_self(self_plan[p]);
      quiet = (p == 0);
      random_routes(140);
      // hold the sender until the block has drained
      quiesce();
      random_routes(135);
      quiet = 1'b1;
      quiesce();
    end

    repeat (6) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
